// File: hdl/rmvs_pkg.sv
// Shared widths, result type and sequencer states for the running statistics block.
package rmvs_pkg;

    // Result field widths
    localparam int W_COUNT  = 16;
    localparam int W_TOTAL  = 32;
    localparam int W_MEAN   = 24;
    localparam int W_MINMAX = 16;
    localparam int W_VAR    = 38;
    localparam int W_SD     = 23;

    // One finished result item
    typedef struct packed {
        logic        [W_COUNT-1:0]  count;
        logic signed [W_TOTAL-1:0]  total;
        logic signed [W_MEAN-1:0]   mean_q8;
        logic signed [W_MINMAX-1:0] minimum;
        logic signed [W_MINMAX-1:0] maximum;
        logic        [W_VAR-1:0]    variance_q8;
        logic        [W_SD-1:0]     stddev_q8;
        logic                       overflow;
    } stat_result_t;

    // Back-end sequencer states
    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MUL1 = 7'b0000010,
        ST_MUL2 = 7'b0000100,
        ST_DIVM = 7'b0001000,
        ST_DIVV = 7'b0010000,
        ST_SQRT = 7'b0100000,
        ST_DONE = 7'b1000000
    } back_state_t;

endpackage

// File: hdl/rmvs_front.sv
// Front end: takes samples, keeps count/sum/min/max and the sum of squares per set.
module rmvs_front #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int MAX_COUNT    = 65535,
    localparam int CW   = $clog2(MAX_COUNT + 1),
    localparam int SUMW = SAMPLE_WIDTH + CW,
    localparam int SQW  = (CW + 2 * SAMPLE_WIDTH - 2 > 64) ? 64 : CW + 2 * SAMPLE_WIDTH - 2,
    localparam int JW   = CW + SUMW + SQW + 2 * SAMPLE_WIDTH + 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           last,
    input  logic                           sample_valid,
    output logic                           sample_ready,
    output logic                           job_valid,
    input  logic                           job_ready,
    output logic [JW-1:0]                  job_data
);

    localparam int SQ1W = 2 * SAMPLE_WIDTH - 1;

    // Stage 1 accumulators
    logic        [CW-1:0]           cnt_reg;
    logic signed [SUMW-1:0]         sum_reg;
    logic signed [SAMPLE_WIDTH-1:0] min_reg;
    logic signed [SAMPLE_WIDTH-1:0] max_reg;
    logic                           drop_reg;

    // Stage 2 item and set snapshot
    logic                           s2_valid_reg;
    logic                           s2_last_reg;
    logic                           s2_acc_reg;
    logic        [SQ1W-1:0]         s2_sq_reg;
    logic        [CW-1:0]           snap_cnt_reg;
    logic signed [SUMW-1:0]         snap_sum_reg;
    logic signed [SAMPLE_WIDTH-1:0] snap_min_reg;
    logic signed [SAMPLE_WIDTH-1:0] snap_max_reg;
    logic                           snap_drop_reg;
    logic        [SQW-1:0]          sumsq_reg;

    logic                           take;
    logic                           acc;
    logic                           first;
    logic        [SAMPLE_WIDTH-1:0] sample_u;
    logic        [SAMPLE_WIDTH-1:0] mag;
    logic        [2*SAMPLE_WIDTH-1:0] sq_full;
    logic        [CW-1:0]           cnt_next;
    logic signed [SUMW-1:0]         sum_next;
    logic signed [SAMPLE_WIDTH-1:0] min_next;
    logic signed [SAMPLE_WIDTH-1:0] max_next;
    logic                           drop_next;
    logic        [SQW-1:0]          sumsq_add;
    logic                           s2_adv;

    // Handshake: stage 2 only stalls on an end-of-set item the queue cannot take
    assign s2_adv       = s2_valid_reg && (!s2_last_reg || job_ready);
    assign sample_ready = !s2_valid_reg || s2_adv;
    assign take         = sample_valid && sample_ready;

    // Magnitude and square of the incoming sample
    assign sample_u = sample;
    assign mag      = sample[SAMPLE_WIDTH-1] ? (~sample_u + 1'b1) : sample_u;
    assign sq_full  = (2 * SAMPLE_WIDTH)'(mag) * (2 * SAMPLE_WIDTH)'(mag);

    // Accumulator update; a full set drops the item and flags it
    always_comb
    begin
        acc       = cnt_reg < CW'(MAX_COUNT);
        first     = cnt_reg == '0;
        cnt_next  = cnt_reg;
        sum_next  = sum_reg;
        min_next  = min_reg;
        max_next  = max_reg;
        drop_next = drop_reg | ~acc;
        if (acc)
        begin
            cnt_next = cnt_reg + 1'b1;
            sum_next = sum_reg + SUMW'(sample);
            if (first || sample < min_reg)
            begin
                min_next = sample;
            end
            if (first || sample > max_reg)
            begin
                max_next = sample;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            sum_reg  <= '0;
            min_reg  <= '0;
            max_reg  <= '0;
            drop_reg <= 1'b0;
        end
        else if (take)
        begin
            if (last)
            begin
                cnt_reg  <= '0;
                sum_reg  <= '0;
                min_reg  <= '0;
                max_reg  <= '0;
                drop_reg <= 1'b0;
            end
            else
            begin
                cnt_reg  <= cnt_next;
                sum_reg  <= sum_next;
                min_reg  <= min_next;
                max_reg  <= max_next;
                drop_reg <= drop_next;
            end
        end
    end

    // Stage 2 valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            s2_valid_reg <= 1'b1;
        end
        else if (s2_adv)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    // Stage 2 payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s2_last_reg   <= last;
            s2_acc_reg    <= acc;
            s2_sq_reg     <= sq_full[SQ1W-1:0];
            snap_cnt_reg  <= cnt_next;
            snap_sum_reg  <= sum_next;
            snap_min_reg  <= min_next;
            snap_max_reg  <= max_next;
            snap_drop_reg <= drop_next;
        end
    end

    // Sum of squares, one item behind stage 1
    assign sumsq_add = s2_acc_reg ? sumsq_reg + SQW'(s2_sq_reg) : sumsq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sumsq_reg <= '0;
        end
        else if (s2_adv)
        begin
            sumsq_reg <= s2_last_reg ? '0 : sumsq_add;
        end
    end

    // Finished set goes to the queue
    assign job_valid = s2_valid_reg && s2_last_reg;
    assign job_data  = {snap_drop_reg, snap_max_reg, snap_min_reg, sumsq_add,
                        snap_sum_reg, snap_cnt_reg};

endmodule

// File: hdl/rmvs_queue.sv
// Two-entry queue between the front end and the back end.
module rmvs_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int FW    = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [FW-1:0]    fill_reg;
    logic             push;
    logic             pop;

    assign in_ready  = fill_reg != FW'(DEPTH);
    assign out_valid = fill_reg != '0;
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// File: hdl/rmvs_back.sv
// Back end: sequential multiply, divide and square root that turn set sums into a result.
module rmvs_back #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int MAX_COUNT    = 65535,
    localparam int CW   = $clog2(MAX_COUNT + 1),
    localparam int SUMW = SAMPLE_WIDTH + CW,
    localparam int SQW  = (CW + 2 * SAMPLE_WIDTH - 2 > 64) ? 64 : CW + 2 * SAMPLE_WIDTH - 2,
    localparam int JW   = CW + SUMW + SQW + 2 * SAMPLE_WIDTH + 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_valid,
    output logic                  job_ready,
    input  logic [JW-1:0]         job_data,
    output logic                  result_valid,
    input  logic                  result_ready,
    output rmvs_pkg::stat_result_t result
);

    import rmvs_pkg::*;

    localparam int DW   = (2 * CW + 2 * SAMPLE_WIDTH - 2 > 64) ? 64
                          : 2 * CW + 2 * SAMPLE_WIDTH - 2;
    localparam int NUMW = DW + 8;
    localparam int NW   = 2 * CW;
    localparam int CTW  = $clog2(NUMW + 1);
    localparam int SXW  = 2 * W_SD;
    localparam int O_SUM = CW;
    localparam int O_SQ  = CW + SUMW;
    localparam int O_MIN = CW + SUMW + SQW;
    localparam int O_MAX = O_MIN + SAMPLE_WIDTH;

    back_state_t      state_reg;
    logic [CTW-1:0]   cnt_reg;

    logic [CW-1:0]    n_reg;
    logic             neg_reg;
    logic [SUMW-1:0]  msum_reg;
    logic [NW-1:0]    n2_reg;
    logic [DW-1:0]    mul_a_reg;
    logic [SUMW-1:0]  mul_b_reg;
    logic [DW-1:0]    d_reg;
    logic [NUMW-1:0]  num_reg;
    logic [NW-1:0]    den_reg;
    logic [NW-1:0]    rem_reg;
    logic [W_VAR-1:0] quot_reg;
    logic [SXW-1:0]   sx_reg;
    logic [W_SD-1:0]  root_reg;
    logic [W_SD:0]    srem_reg;
    stat_result_t     result_reg;

    // Job fields
    logic        [CW-1:0]           job_cnt;
    logic signed [SUMW-1:0]         job_sum;
    logic        [SUMW-1:0]         job_sum_u;
    logic        [SQW-1:0]          job_sumsq;
    logic signed [SAMPLE_WIDTH-1:0] job_min;
    logic signed [SAMPLE_WIDTH-1:0] job_max;
    logic                           job_drop;
    logic        [63:0]             cnt_ext;
    logic signed [63:0]             sum_ext;
    logic signed [63:0]             min_ext;
    logic signed [63:0]             max_ext;

    logic             load;
    logic             cnt_last;
    logic [DW-1:0]    mul_pp;
    logic [NW:0]      div_trial;
    logic [NW:0]      div_diff;
    logic             div_ge;
    logic [NW-1:0]    div_rem_next;
    logic [W_VAR-1:0] div_quot_next;
    logic [W_MEAN-1:0] mean_mag;
    logic [W_MEAN-1:0] mean_val;
    logic [W_SD+2:0]  sq_tr;
    logic [W_SD+2:0]  sq_trial;
    logic [W_SD+2:0]  sq_diff;
    logic             sq_ge;
    logic [W_SD:0]    srem_next;
    logic [W_SD-1:0]  root_next;

    // Unpack the job
    assign job_cnt   = job_data[CW-1:0];
    assign job_sum   = job_data[O_SUM +: SUMW];
    assign job_sum_u = job_data[O_SUM +: SUMW];
    assign job_sumsq = job_data[O_SQ +: SQW];
    assign job_min   = job_data[O_MIN +: SAMPLE_WIDTH];
    assign job_max   = job_data[O_MAX +: SAMPLE_WIDTH];
    assign job_drop  = job_data[JW-1];
    assign cnt_ext   = 64'(job_cnt);
    assign sum_ext   = 64'(job_sum);
    assign min_ext   = 64'(job_min);
    assign max_ext   = 64'(job_max);

    assign job_ready    = state_reg == ST_IDLE;
    assign load         = job_valid && job_ready;
    assign result_valid = state_reg == ST_DONE;
    assign result       = result_reg;
    assign cnt_last     = cnt_reg == CTW'(1);

    // Shift-add multiplier step
    assign mul_pp = mul_b_reg[0] ? mul_a_reg : '0;

    // Restoring divider step, one quotient bit per cycle
    always_comb
    begin
        div_trial     = {rem_reg, num_reg[NUMW-1]};
        div_diff      = div_trial - {1'b0, den_reg};
        div_ge        = div_trial >= {1'b0, den_reg};
        div_rem_next  = div_ge ? div_diff[NW-1:0] : div_trial[NW-1:0];
        div_quot_next = {quot_reg[W_VAR-2:0], div_ge};
        mean_mag      = div_quot_next[W_MEAN-1:0];
        mean_val      = neg_reg ? (~mean_mag + 1'b1) : mean_mag;
    end

    // Square root step, one root bit per cycle
    always_comb
    begin
        sq_tr     = {srem_reg, sx_reg[SXW-1 -: 2]};
        sq_trial  = {1'b0, root_reg, 2'b01};
        sq_diff   = sq_tr - sq_trial;
        sq_ge     = sq_tr >= sq_trial;
        srem_next = sq_ge ? sq_diff[W_SD:0] : sq_tr[W_SD:0];
        root_next = {root_reg[W_SD-2:0], sq_ge};
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (load)
                    begin
                        state_reg <= ST_MUL1;
                        cnt_reg   <= CTW'(CW);
                    end
                end
                ST_MUL1:
                begin
                    if (cnt_last)
                    begin
                        state_reg <= ST_MUL2;
                        cnt_reg   <= CTW'(SUMW);
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_MUL2:
                begin
                    if (cnt_last)
                    begin
                        state_reg <= ST_DIVM;
                        cnt_reg   <= CTW'(NUMW);
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_DIVM:
                begin
                    if (cnt_last)
                    begin
                        state_reg <= ST_DIVV;
                        cnt_reg   <= CTW'(NUMW);
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_DIVV:
                begin
                    if (cnt_last)
                    begin
                        state_reg <= ST_SQRT;
                        cnt_reg   <= CTW'(W_SD);
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_SQRT:
                begin
                    if (cnt_last)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_DONE:
                begin
                    if (result_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (load)
                begin
                    n_reg     <= job_cnt;
                    neg_reg   <= job_sum[SUMW-1];
                    msum_reg  <= job_sum[SUMW-1] ? (~job_sum_u + 1'b1) : job_sum_u;
                    n2_reg    <= NW'(job_cnt) * NW'(job_cnt);
                    mul_a_reg <= DW'(job_sumsq);
                    mul_b_reg <= SUMW'(job_cnt);
                    d_reg     <= '0;
                    result_reg.count    <= cnt_ext[W_COUNT-1:0];
                    result_reg.total    <= sum_ext[W_TOTAL-1:0];
                    result_reg.minimum  <= min_ext[W_MINMAX-1:0];
                    result_reg.maximum  <= max_ext[W_MINMAX-1:0];
                    result_reg.overflow <= job_drop;
                end
            end
            // d = n * sumsq
            ST_MUL1:
            begin
                d_reg <= d_reg + mul_pp;
                if (cnt_last)
                begin
                    mul_a_reg <= DW'(msum_reg);
                    mul_b_reg <= msum_reg;
                end
                else
                begin
                    mul_a_reg <= {mul_a_reg[DW-2:0], 1'b0};
                    mul_b_reg <= {1'b0, mul_b_reg[SUMW-1:1]};
                end
            end
            // d -= sum^2
            ST_MUL2:
            begin
                d_reg <= d_reg - mul_pp;
                if (cnt_last)
                begin
                    num_reg  <= NUMW'({msum_reg, 8'h00});
                    den_reg  <= NW'(n_reg);
                    rem_reg  <= '0;
                    quot_reg <= '0;
                end
                else
                begin
                    mul_a_reg <= {mul_a_reg[DW-2:0], 1'b0};
                    mul_b_reg <= {1'b0, mul_b_reg[SUMW-1:1]};
                end
            end
            // mean = 256 * |sum| / n
            ST_DIVM:
            begin
                num_reg  <= {num_reg[NUMW-2:0], 1'b0};
                rem_reg  <= div_rem_next;
                quot_reg <= div_quot_next;
                if (cnt_last)
                begin
                    result_reg.mean_q8 <= mean_val;
                    num_reg  <= {d_reg, 8'h00};
                    den_reg  <= n2_reg;
                    rem_reg  <= '0;
                    quot_reg <= '0;
                end
            end
            // variance = 256 * d / n^2
            ST_DIVV:
            begin
                num_reg  <= {num_reg[NUMW-2:0], 1'b0};
                rem_reg  <= div_rem_next;
                quot_reg <= div_quot_next;
                if (cnt_last)
                begin
                    result_reg.variance_q8 <= div_quot_next;
                    sx_reg   <= {div_quot_next, 8'h00};
                    root_reg <= '0;
                    srem_reg <= '0;
                end
            end
            // stddev = isqrt(variance * 256)
            ST_SQRT:
            begin
                sx_reg   <= {sx_reg[SXW-3:0], 2'b00};
                root_reg <= root_next;
                srem_reg <= srem_next;
                if (cnt_last)
                begin
                    result_reg.stddev_q8 <= root_next;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: hdl/running_mean_variance_stats.sv
// Path: a sample is registered into the stage 1 accumulators, its square into stage 2 and then
// into the sum of squares; a set's result then passes through the bit-serial multiply, the two
// restoring divides and the square root in the back end.
// Throughput: one sample per cycle; sets shorter than the back-end time stall the input
// once the two-entry queue holds two finished sets.
// Reset: asynchronous, active low; clears all accumulators, the queue and the sequencer.
module running_mean_variance_stats #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int MAX_COUNT    = 65535
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic signed [SAMPLE_WIDTH-1:0]        sample,
    input  logic                                  last,
    input  logic                                  sample_valid,
    output logic                                  sample_ready,
    output logic        [rmvs_pkg::W_COUNT-1:0]   count,
    output logic signed [rmvs_pkg::W_TOTAL-1:0]   total,
    output logic signed [rmvs_pkg::W_MEAN-1:0]    mean_q8,
    output logic signed [rmvs_pkg::W_MINMAX-1:0]  minimum,
    output logic signed [rmvs_pkg::W_MINMAX-1:0]  maximum,
    output logic        [rmvs_pkg::W_VAR-1:0]     variance_q8,
    output logic        [rmvs_pkg::W_SD-1:0]      stddev_q8,
    output logic                                  overflow,
    output logic                                  result_valid,
    input  logic                                  result_ready
);

    import rmvs_pkg::*;

    localparam int CW   = $clog2(MAX_COUNT + 1);
    localparam int SUMW = SAMPLE_WIDTH + CW;
    localparam int SQW  = (CW + 2 * SAMPLE_WIDTH - 2 > 64) ? 64 : CW + 2 * SAMPLE_WIDTH - 2;
    localparam int JW   = CW + SUMW + SQW + 2 * SAMPLE_WIDTH + 1;

    logic          q_in_valid;
    logic          q_in_ready;
    logic [JW-1:0] q_in_data;
    logic          q_out_valid;
    logic          q_out_ready;
    logic [JW-1:0] q_out_data;
    stat_result_t  res;

    rmvs_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .MAX_COUNT    (MAX_COUNT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .last         (last),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .job_valid    (q_in_valid),
        .job_ready    (q_in_ready),
        .job_data     (q_in_data)
    );

    rmvs_queue #(
        .WIDTH (JW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_data   (q_in_data),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_data  (q_out_data)
    );

    rmvs_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .MAX_COUNT    (MAX_COUNT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (q_out_valid),
        .job_ready    (q_out_ready),
        .job_data     (q_out_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (res)
    );

    // Result fields
    assign count       = res.count;
    assign total       = res.total;
    assign mean_q8     = res.mean_q8;
    assign minimum     = res.minimum;
    assign maximum     = res.maximum;
    assign variance_q8 = res.variance_q8;
    assign stddev_q8   = res.stddev_q8;
    assign overflow    = res.overflow;

    // Input stalls only when a finished set is blocked by a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> !q_in_ready)
        else $error("input stalled while the queue had room");

    // Root never exceeds the square root of its operand
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (46'(stddev_q8) * 46'(stddev_q8)) <= {variance_q8, 8'h00})
        else $error("stddev_q8 too large for variance_q8");

    // Extremes stay ordered when they fit the output field
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (SAMPLE_WIDTH <= W_MINMAX) |-> minimum <= maximum)
        else $error("minimum above maximum");

endmodule

// File: verif/running_mean_variance_stats_tb.sv
// Self-checking testbench for the running mean/variance/stddev statistics block.
module running_mean_variance_stats_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rmvs_pkg::*;

    localparam int                 SAMPLE_BITS = 16;
    localparam int unsigned        FULL_COUNT  = 65535;
    localparam logic signed [15:0] SAMPLE_MAX  = 16'sh7FFF;
    localparam logic signed [15:0] SAMPLE_MIN  = 16'sh8000;
    localparam int                 STALL_LIMIT = 20000;
    localparam int                 DRAIN_WAIT  = 250;
    localparam int                 RANDOM_ITEMS = 1700;
    localparam int                 HOLD_CYCLES  = 3000;
    localparam int unsigned        HOLD_AFTER   = 30;

    // Predicts per-set statistics and holds them until the block delivers them
    class set_stats_board;
        int unsigned     n_acc;
        longint          sum_acc;
        longint unsigned sq_acc;
        longint          min_acc;
        longint          max_acc;
        bit              dropped;
        stat_result_t    pending_stats[$];
        int unsigned     mismatches;
        int unsigned     checked;

        function new();
            clear_set();
            mismatches = 0;
            checked    = 0;
        endfunction

        function void clear_set();
            n_acc   = 0;
            sum_acc = 0;
            sq_acc  = 0;
            min_acc = 0;
            max_acc = 0;
            dropped = 1'b0;
        endfunction

        // Floor square root, one result bit at a time
        function longint unsigned floor_root(longint unsigned x);
            longint unsigned r;
            longint unsigned t;
            r = 0;
            for (int i = 23; i >= 0; i--)
            begin
                t = r | (64'd1 << i);
                if (t * t <= x)
                    r = t;
            end
            return r;
        endfunction

        // Accumulate one accepted sample; on the last one, queue the set's statistics
        function void note_sample(logic signed [15:0] s, bit lst);
            longint          sv;
            longint unsigned ms;
            longint unsigned n64;
            longint unsigned msum;
            longint unsigned mq;
            longint unsigned d;
            longint unsigned n2;
            longint unsigned mean_v;
            longint unsigned var_v;
            longint unsigned sd_v;
            stat_result_t    want;
            sv = longint'(s);
            if (n_acc < FULL_COUNT)
            begin
                ms = (sv < 0) ? longint'(-sv) : longint'(sv);
                if (n_acc == 0)
                begin
                    min_acc = sv;
                    max_acc = sv;
                end
                else
                begin
                    if (sv < min_acc)
                        min_acc = sv;
                    if (sv > max_acc)
                        max_acc = sv;
                end
                sum_acc = sum_acc + sv;
                sq_acc  = sq_acc + ms * ms;
                n_acc++;
            end
            else
            begin
                // set is full: the sample is dropped and flagged
                dropped = 1'b1;
            end
            if (!lst)
                return;

            n64    = longint'(n_acc);
            msum   = (sum_acc < 0) ? longint'(-sum_acc) : longint'(sum_acc);
            mq     = (msum * 256) / n64;
            d      = n64 * sq_acc - msum * msum;
            n2     = n64 * n64;
            mean_v = (sum_acc < 0) ? (64'd0 - mq) : mq;
            var_v  = (d / n2) * 256 + ((d % n2) * 256) / n2;
            sd_v   = floor_root({18'd0, var_v[37:0], 8'h00});

            want.count       = n64[15:0];
            want.total       = sum_acc[31:0];
            want.mean_q8     = mean_v[23:0];
            want.minimum     = min_acc[15:0];
            want.maximum     = max_acc[15:0];
            want.variance_q8 = var_v[37:0];
            want.stddev_q8   = sd_v[22:0];
            want.overflow    = dropped;
            pending_stats.push_back(want);
            clear_set();
        endfunction

        function void field_check(string name, longint want_v, longint got_v);
            if (want_v != got_v)
            begin
                $error("%s: expected %0d, got %0d", name, want_v, got_v);
                mismatches++;
            end
        endfunction

        // Compare one delivered result item with the oldest predicted set
        function void check_result(stat_result_t got);
            stat_result_t want;
            if (pending_stats.size() == 0)
            begin
                $error("result item arrived with no set pending");
                mismatches++;
                return;
            end
            want = pending_stats.pop_front();
            checked++;
            field_check("count",       longint'(want.count),       longint'(got.count));
            field_check("total",       longint'(want.total),       longint'(got.total));
            field_check("mean_q8",     longint'(want.mean_q8),     longint'(got.mean_q8));
            field_check("minimum",     longint'(want.minimum),     longint'(got.minimum));
            field_check("maximum",     longint'(want.maximum),     longint'(got.maximum));
            field_check("variance_q8", longint'(want.variance_q8), longint'(got.variance_q8));
            field_check("stddev_q8",   longint'(want.stddev_q8),   longint'(got.stddev_q8));
            field_check("overflow",    longint'(want.overflow),    longint'(got.overflow));
        endfunction
    endclass

    logic                                  clk;
    logic                                  rst_n;
    logic signed [SAMPLE_BITS-1:0]         sample;
    logic                                  last;
    logic                                  sample_valid;
    logic                                  sample_ready;
    logic        [W_COUNT-1:0]             count;
    logic signed [W_TOTAL-1:0]             total;
    logic signed [W_MEAN-1:0]              mean_q8;
    logic signed [W_MINMAX-1:0]            minimum;
    logic signed [W_MINMAX-1:0]            maximum;
    logic        [W_VAR-1:0]               variance_q8;
    logic        [W_SD-1:0]                stddev_q8;
    logic                                  overflow;
    logic                                  result_valid;
    logic                                  result_ready;

    set_stats_board board;
    stat_result_t   seen_stats;
    bit             calm;
    int unsigned    items_sent;
    int unsigned    sets_sent;
    int             stall_cycles;

    running_mean_variance_stats #(
        .SAMPLE_WIDTH (SAMPLE_BITS),
        .MAX_COUNT    (FULL_COUNT)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .last         (last),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .count        (count),
        .total        (total),
        .mean_q8      (mean_q8),
        .minimum      (minimum),
        .maximum      (maximum),
        .variance_q8  (variance_q8),
        .stddev_q8    (stddev_q8),
        .overflow     (overflow),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one sample item and wait for it to be taken
    task automatic send_sample(input logic signed [15:0] s, input bit lst);
        while (!calm && $urandom_range(99) < 26)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= s;
        last         <= lst;
        do
            @(posedge clk);
        while (!sample_ready);
        board.note_sample(s, lst);
        items_sent++;
        if (lst)
            sets_sent++;
        @(negedge clk);
    endtask

    // Mix of extremes, small values around zero and full-range values
    function automatic logic signed [15:0] pick_sample();
        int          r;
        int          k;
        logic [15:0] raw;
        r = int'($urandom_range(99));
        if (r < 10)
            return SAMPLE_MAX;
        if (r < 20)
            return SAMPLE_MIN;
        if (r < 35)
        begin
            k = int'($urandom_range(15)) - 8;
            return k[15:0];
        end
        raw = 16'($urandom());
        return raw;
    endfunction

    // Mostly short sets so results come often and the back end stays busy
    function automatic int unsigned pick_set_len();
        int r;
        r = int'($urandom_range(99));
        if (r < 70)
            return $urandom_range(1, 6);
        if (r < 95)
            return $urandom_range(7, 40);
        return $urandom_range(41, 200);
    endfunction

    // Receiver: random back-pressure plus one long hold-off
    initial
    begin : receiver
        int  hold_left;
        bit  hold_done;
        result_ready = 1'b0;
        hold_left    = 0;
        hold_done    = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_left != 0)
            begin
                result_ready <= 1'b0;
                hold_left--;
            end
            else if (!hold_done && board.checked >= HOLD_AFTER)
            begin
                result_ready <= 1'b0;
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            else
                result_ready <= calm ? 1'b1 : ($urandom_range(99) >= 26);
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            seen_stats.count       = count;
            seen_stats.total       = total;
            seen_stats.mean_q8     = mean_q8;
            seen_stats.minimum     = minimum;
            seen_stats.maximum     = maximum;
            seen_stats.variance_q8 = variance_q8;
            seen_stats.stddev_q8   = stddev_q8;
            seen_stats.overflow    = overflow;
            board.check_result(seen_stats);
        end
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_valid && sample_ready) || (result_valid && result_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // Stimulus
    initial
    begin : stimulus
        int unsigned set_len;
        int unsigned rand_items;
        board        = new();
        calm         = 1'b0;
        items_sent   = 0;
        sets_sent    = 0;
        stall_cycles = 0;
        rand_items   = 0;
        rst_n        = 1'b0;
        sample       = '0;
        last         = 1'b0;
        sample_valid = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: single-sample sets at the extremes, zero and minus one
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(16'sd0, 1'b1);
        send_sample(-16'sd1, 1'b1);
        // widest spread, with and without a third sample
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(16'sd1, 1'b1);
        // mean of a negative and a positive set; the positive one truncates toward zero
        send_sample(-16'sd1, 1'b0);
        send_sample(-16'sd2, 1'b1);
        send_sample(16'sd1, 1'b0);
        send_sample(16'sd2, 1'b0);
        send_sample(16'sd2, 1'b1);
        // constant set: zero variance
        repeat (3) send_sample(16'sd5, 1'b0);
        send_sample(16'sd5, 1'b1);
        // mixed set
        send_sample(-16'sd7, 1'b0);
        send_sample(16'sd3, 1'b0);
        send_sample(16'sd100, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(16'sd0, 1'b1);

        // Random sets, with a stretch of no idling in the middle
        while (rand_items < RANDOM_ITEMS)
        begin
            set_len = pick_set_len();
            for (int unsigned i = 0; i < set_len; i++)
            begin
                calm = (rand_items >= 600 && rand_items < 1000);
                send_sample(pick_sample(), i == set_len - 1);
                rand_items++;
            end
        end
        calm = 1'b0;
        sample_valid <= 1'b0;

        while (board.pending_stats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Checked %0d result items from %0d sets (%0d samples): directed extremes,",
                 board.checked, sets_sent, items_sent);
        $display("short random sets, a stretch with no idling and a long output hold-off.");
        if (board.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
hdl/rmvs_pkg.sv
hdl/rmvs_front.sv
hdl/rmvs_queue.sv
hdl/rmvs_back.sv
hdl/running_mean_variance_stats.sv
verif/running_mean_variance_stats_tb.sv
